// ===== rtl/kms_pkg.sv =====
// Package: shared constants and types of the keypad matrix scanner.
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;

    // Matrix and field geometry
    localparam int NUM_COLUMNS   = 4;
    localparam int NUM_ROWS      = 4;
    localparam int TIMER_BITS    = 16;
    localparam int COL_BITS      = 3;
    localparam int ROW_BITS      = 3;
    localparam int CODE_BITS     = 7;
    localparam int HOLD_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Key code is (base + column) * row
    localparam logic [4:0] COL_CODE_BASE = 5'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT   = 2'd3;

    // Configuration reset values
    localparam logic [CFG_DATA_BITS-1:0] SETTLE_RESET   = 16'd5;
    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] LONG_RESET     = 16'd1500;
    localparam logic [CFG_DATA_BITS-1:0] REPEAT_RESET   = 16'd3000;

    // One result item
    typedef struct packed {
        logic [NUM_COLUMNS-1:0] column_drive;
        logic                   key_held;
        logic                   press_event;
        logic [CODE_BITS-1:0]   press_code;
        logic                   release_event;
        logic [CODE_BITS-1:0]   release_code;
        logic                   beep_pulse;
        logic [HOLD_BITS-1:0]   hold_count;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/kms_in_if.sv =====
// Interface: tick channel carrying the sampled row lines.
`timescale 1ns / 1ps
`default_nettype none
interface kms_in_if;
    logic                          valid;
    logic                          ready;
    logic [kms_pkg::NUM_ROWS-1:0]  row_lines;

    modport source (output valid, output row_lines, input ready);
    modport sink   (input valid, input row_lines, output ready);
endinterface
`default_nettype wire

// ===== rtl/kms_out_if.sv =====
// Interface: result channel carrying the per-tick keypad status.
`timescale 1ns / 1ps
`default_nettype none
interface kms_out_if;
    logic             valid;
    logic             ready;
    kms_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/keypad_matrix_scan_debounce.sv =====
// Top level: keypad matrix scanner with debounce and long-hold detection.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------
//   i_in     | in  | valid / ready | row_lines[3:0]
//   o_out    | out | valid / ready | column_drive, key_held, press/release
//            |     |               | events and codes, beep_pulse, hold_count
//   cfg      | in  | i_cfg_we      | i_cfg_idx[1:0], i_cfg_data[15:0]
//
// One tick is accepted per clock while input ready is high. The scan state
// updates at acceptance and the result enters a two-entry output buffer,
// so ticks keep flowing while one result waits.
// Input ready drops only while both buffer entries are full.
// Synchronous active-low reset clears scan state and buffer flags and reloads config defaults.
`timescale 1ns / 1ps
`default_nettype none
module keypad_matrix_scan_debounce (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [kms_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [kms_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    kms_in_if.sink                                  i_in,
    kms_out_if.source                               o_out
);
    import kms_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CHECK,
        PH_DEBOUNCE,
        PH_LONG
    } t_phase;

    // Configuration
    logic [CFG_DATA_BITS-1:0] r_settle, r_debounce, r_long, r_repeat;

    // Scan state
    t_phase                r_phase, n_phase;
    logic [COL_BITS-1:0]   r_col, n_col;
    logic [ROW_BITS-1:0]   r_row, n_row;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [HOLD_BITS-1:0]  r_hold, n_hold;
    logic                  r_held, n_held;
    logic [CODE_BITS-1:0]  r_press_code, n_press_code;
    logic [CODE_BITS-1:0]  r_release_code, n_release_code;

    // Output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;

    logic                  w_accept, w_pop;
    logic [ROW_BITS-1:0]   w_row;
    logic [TIMER_BITS-1:0] w_timer_dec;
    logic [CODE_BITS-1:0]  w_key_code;
    logic [7:0]            w_product;
    logic                  w_press, w_release, w_beep;
    t_result               w_result;

    assign i_in.ready  = !r_skid_valid;
    assign w_accept    = i_in.valid && !r_skid_valid;
    assign w_pop       = r_out_valid && o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Pick the lowest active row
    always_comb begin
        w_row = '0;
        for (int i = NUM_ROWS - 1; i >= 0; i--) begin
            if (i_in.row_lines[i]) begin
                w_row = ROW_BITS'(i + 1);
            end
        end
    end

    // Count the wait timer down, holding at zero
    assign w_timer_dec = (r_timer != '0) ? r_timer - 1'b1 : r_timer;

    // Key code from current column and latched row
    assign w_product  = (8'(COL_CODE_BASE) + 8'(r_col)) * 8'(r_row);
    assign w_key_code = w_product[CODE_BITS-1:0];

    // Advance the scan phase for one tick
    always_comb begin
        n_phase        = r_phase;
        n_col          = r_col;
        n_row          = r_row;
        n_timer        = w_timer_dec;
        n_hold         = r_hold;
        n_held         = r_held;
        n_press_code   = r_press_code;
        n_release_code = r_release_code;
        w_press        = 1'b0;
        w_release      = 1'b0;
        w_beep         = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_col >= COL_BITS'(NUM_COLUMNS)) begin
                    n_col = '0;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_timer = TIMER_BITS'(r_settle);
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (w_timer_dec == '0) begin
                    n_row = w_row;
                    if (w_row != '0) begin
                        n_timer = TIMER_BITS'(r_debounce);
                        n_phase = PH_DEBOUNCE;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_DEBOUNCE: begin
                if (w_timer_dec == '0) begin
                    if (w_row == r_row) begin
                        w_beep       = 1'b1;
                        w_press      = 1'b1;
                        n_timer      = TIMER_BITS'(r_long);
                        n_phase      = PH_LONG;
                        n_held       = 1'b1;
                        n_hold       = '0;
                        n_press_code = w_key_code;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_LONG: begin
                if (w_timer_dec == '0) begin
                    if (w_row == r_row) begin
                        n_timer = TIMER_BITS'(r_repeat);
                        n_hold  = r_hold + 1'b1;
                        w_beep  = 1'b1;
                    end else begin
                        n_held         = 1'b0;
                        w_release      = 1'b1;
                        n_release_code = (r_hold != '0) ? '0 : w_key_code;
                        n_phase        = PH_IDLE;
                    end
                end
            end
        endcase
    end

    // Assemble the result from post-tick state
    always_comb begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            w_result.column_drive[c] = (n_col == COL_BITS'(c + 1));
        end
        w_result.key_held      = n_held;
        w_result.press_event   = w_press;
        w_result.press_code    = n_press_code;
        w_result.release_event = w_release;
        w_result.release_code  = n_release_code;
        w_result.beep_pulse    = w_beep;
        w_result.hold_count    = n_hold;
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle   <= SETTLE_RESET;
            r_debounce <= DEBOUNCE_RESET;
            r_long     <= LONG_RESET;
            r_repeat   <= REPEAT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETTLE:   r_settle   <= i_cfg_data;
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_LONG:     r_long     <= i_cfg_data;
                CFG_REPEAT:   r_repeat   <= i_cfg_data;
            endcase
        end
    end

    // Update scan state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_col          <= '0;
            r_row          <= '0;
            r_timer        <= '0;
            r_hold         <= '0;
            r_held         <= 1'b0;
            r_press_code   <= '0;
            r_release_code <= '0;
        end else if (w_accept) begin
            r_phase        <= n_phase;
            r_col          <= n_col;
            r_row          <= n_row;
            r_timer        <= n_timer;
            r_hold         <= n_hold;
            r_held         <= n_held;
            r_press_code   <= n_press_code;
            r_release_code <= n_release_code;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else if (w_accept) begin
                r_out_data <= w_result;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid) begin
                r_out_data  <= w_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= w_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/kms_checker.sv =====
// Checker: port-level assertions for the keypad scanner, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module kms_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire kms_pkg::t_result i_out_data
);
    import kms_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Drive at most one column
    a_col_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_out_data.column_drive))
        else $error("more than one column driven");

    // Confirm a press with a beep, the held flag, a cleared hold count and no release
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.press_event |->
            i_out_data.beep_pulse && i_out_data.key_held &&
            i_out_data.hold_count == '0 && !i_out_data.release_event)
        else $error("press event without beep, held flag or zero count");

    // Drop the held flag on release, without a beep
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.release_event |->
            !i_out_data.key_held && !i_out_data.beep_pulse)
        else $error("release event with key still held or beeping");

    // Release code is zero after any passed hold check
    a_release_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.release_event && i_out_data.hold_count != '0 |->
            i_out_data.release_code == '0)
        else $error("long-held release gave a nonzero code");

endmodule

bind keypad_matrix_scan_debounce kms_checker u_kms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

// ===== verif/tb_keypad_matrix_scan_debounce.sv =====
// Testbench: drives row-line ticks into the keypad scanner and checks every status item.
`timescale 1ns / 1ps
`default_nettype none
module tb_keypad_matrix_scan_debounce;
    import kms_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_SETTLE,
        SCAN_DEBOUNCE,
        SCAN_HOLD
    } t_scan_phase;

    localparam int GUARD_TICKS = 4000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    kms_in_if  tick_ch ();
    kms_out_if status_ch ();

    keypad_matrix_scan_debounce DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_ch),
        .o_out      (status_ch)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Scanner shadow: timing registers and scan state
    logic [CFG_DATA_BITS-1:0] timing_regs [4];
    t_scan_phase              scan_ph;
    logic [COL_BITS-1:0]      scan_col;
    logic [ROW_BITS-1:0]      scan_row;
    logic [TIMER_BITS-1:0]    wait_cnt;
    logic [HOLD_BITS-1:0]     hold_cnt;
    logic                     key_down;
    logic [CODE_BITS-1:0]     press_code_q;
    logic [CODE_BITS-1:0]     release_code_q;

    t_result                  status_q [$];
    t_result                  last_status;

    // Virtual keypad: one key at key_col pulls the rows in key_mask
    logic [COL_BITS-1:0]      key_col;
    logic [NUM_ROWS-1:0]      key_mask;
    int                       noise_pct;
    int                       tx_idle_pct;
    int                       rx_idle_pct;
    int                       ticks_sent;
    int                       err_count;

    function automatic void reset_scanner();
        timing_regs[CFG_SETTLE]   = SETTLE_RESET;
        timing_regs[CFG_DEBOUNCE] = DEBOUNCE_RESET;
        timing_regs[CFG_LONG]     = LONG_RESET;
        timing_regs[CFG_REPEAT]   = REPEAT_RESET;
        scan_ph        = SCAN_IDLE;
        scan_col       = '0;
        scan_row       = '0;
        wait_cnt       = '0;
        hold_cnt       = '0;
        key_down       = 1'b0;
        press_code_q   = '0;
        release_code_q = '0;
    endfunction

    function automatic logic [ROW_BITS-1:0] lowest_active_row(input logic [NUM_ROWS-1:0] rows);
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (rows[i]) return ROW_BITS'(i + 1);
        end
        return '0;
    endfunction

    function automatic logic [CODE_BITS-1:0] current_key_code();
        logic [9:0] prod;
        prod = (10'(COL_CODE_BASE) + 10'(scan_col)) * 10'(scan_row);
        return prod[CODE_BITS-1:0];
    endfunction

    // Advance the shadow scanner by one tick and return the status it shows
    function automatic t_result scan_tick(input logic [NUM_ROWS-1:0] rows);
        t_result             r;
        logic [ROW_BITS-1:0] hit;
        r   = '0;
        hit = lowest_active_row(rows);
        if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
        case (scan_ph)
            SCAN_IDLE: begin
                scan_col = scan_col + 1'b1;
                if (int'(scan_col) > NUM_COLUMNS) begin
                    scan_col = '0;
                end else begin
                    wait_cnt = timing_regs[CFG_SETTLE];
                    scan_ph  = SCAN_SETTLE;
                end
            end
            SCAN_SETTLE: begin
                if (wait_cnt == '0) begin
                    scan_row = hit;
                    if (hit != '0) begin
                        wait_cnt = timing_regs[CFG_DEBOUNCE];
                        scan_ph  = SCAN_DEBOUNCE;
                    end else begin
                        scan_ph = SCAN_IDLE;
                    end
                end
            end
            SCAN_DEBOUNCE: begin
                if (wait_cnt == '0) begin
                    if (hit == scan_row) begin
                        r.beep_pulse  = 1'b1;
                        r.press_event = 1'b1;
                        wait_cnt      = timing_regs[CFG_LONG];
                        scan_ph       = SCAN_HOLD;
                        key_down      = 1'b1;
                        hold_cnt      = '0;
                        press_code_q  = current_key_code();
                    end else begin
                        scan_ph = SCAN_IDLE;
                    end
                end
            end
            default: begin
                if (wait_cnt == '0) begin
                    if (hit == scan_row) begin
                        wait_cnt     = timing_regs[CFG_REPEAT];
                        hold_cnt     = hold_cnt + 1'b1;
                        r.beep_pulse = 1'b1;
                    end else begin
                        key_down        = 1'b0;
                        r.release_event = 1'b1;
                        release_code_q  = (hold_cnt != '0) ? '0 : current_key_code();
                        scan_ph         = SCAN_IDLE;
                    end
                end
            end
        endcase
        if (scan_col >= 1 && int'(scan_col) <= NUM_COLUMNS)
            r.column_drive = NUM_COLUMNS'(1) << (scan_col - 1'b1);
        r.key_held     = key_down;
        r.press_code   = press_code_q;
        r.release_code = release_code_q;
        r.hold_count   = hold_cnt;
        return r;
    endfunction

    // Send one tick, idling first at random; predict its status on acceptance
    task automatic send_tick(input logic [NUM_ROWS-1:0] rows);
        while ($urandom_range(99) < tx_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.row_lines <= rows;
        do @(posedge i_clk); while (!tick_ch.ready);
        last_status = scan_tick(rows);
        status_q.push_back(last_status);
        ticks_sent++;
    endtask

    // Rows seen while the shadow scanner drives its current column
    task automatic key_tick();
        logic [NUM_ROWS-1:0] rows;
        rows = (key_col != '0 && key_col == scan_col) ? key_mask : '0;
        if ($urandom_range(99) < noise_pct) rows = rows ^ NUM_ROWS'($urandom);
        send_tick(rows);
    endtask

    // Hold off the sender until every expected status item has come
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        timing_regs[idx] = val;
    endtask

    task automatic load_timing(input logic [CFG_DATA_BITS-1:0] settle_t, debounce_t,
                               input logic [CFG_DATA_BITS-1:0] hold_t, rep_t);
        wait_idle();
        write_reg(CFG_SETTLE, settle_t);
        write_reg(CFG_DEBOUNCE, debounce_t);
        write_reg(CFG_LONG, hold_t);
        write_reg(CFG_REPEAT, rep_t);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Stall the receiver at random and compare each status item with the oldest prediction
    always @(posedge i_clk) begin : status_check
        t_result want;
        status_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        if (i_rst_n && status_ch.valid && status_ch.ready) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected status item %p", $time, status_ch.data);
                err_count++;
            end else begin
                want = status_q.pop_front();
                check_field("column_drive", 8'(want.column_drive), 8'(status_ch.data.column_drive));
                check_field("key_held", 8'(want.key_held), 8'(status_ch.data.key_held));
                check_field("press_event", 8'(want.press_event), 8'(status_ch.data.press_event));
                check_field("press_code", 8'(want.press_code), 8'(status_ch.data.press_code));
                check_field("release_event", 8'(want.release_event),
                            8'(status_ch.data.release_event));
                check_field("release_code", 8'(want.release_code),
                            8'(status_ch.data.release_code));
                check_field("beep_pulse", 8'(want.beep_pulse), 8'(status_ch.data.beep_pulse));
                check_field("hold_count", want.hold_count, status_ch.data.hold_count);
            end
        end
    end

    // Reset timing: press column 2 row 3, drop it during debounce so the scan resumes
    task automatic test_reset_timing();
        int n;
        key_col  = 3'd2;
        key_mask = 4'b0100;
        for (n = 0; n < GUARD_TICKS && scan_ph != SCAN_DEBOUNCE; n++) key_tick();
        key_col = '0;
        for (n = 0; n < GUARD_TICKS && scan_ph != SCAN_IDLE; n++) key_tick();
    endtask

    // Zero waits with several rows down: lowest row wins, long hold releases with code 0
    task automatic test_zero_waits();
        int n;
        load_timing('0, '0, '0, '0);
        key_col  = 3'd4;
        key_mask = 4'b1010;
        for (n = 0; n < GUARD_TICKS && hold_cnt != 8'd3; n++) key_tick();
        key_col = '0;
        for (n = 0; n < GUARD_TICKS && !last_status.release_event; n++) key_tick();
    endtask

    // Short press gives a nonzero release code; a row change in debounce drops the key
    task automatic test_short_press();
        int n;
        load_timing(16'd1, 16'd2, 16'd8, 16'd3);
        key_col  = 3'd1;
        key_mask = 4'b1000;
        for (n = 0; n < GUARD_TICKS && !last_status.press_event; n++) key_tick();
        key_col = '0;
        for (n = 0; n < GUARD_TICKS && !last_status.release_event; n++) key_tick();
        key_col  = 3'd3;
        key_mask = 4'b0001;
        for (n = 0; n < GUARD_TICKS && scan_ph != SCAN_DEBOUNCE; n++) key_tick();
        key_mask = 4'b0010;
        for (n = 0; n < GUARD_TICKS && scan_ph != SCAN_IDLE; n++) key_tick();
        key_col = '0;
    endtask

    // Hold until the hold counter wraps to zero, then release right after the wrap
    task automatic test_hold_wrap();
        int n;
        load_timing('0, '0, '0, '0);
        key_col  = 3'd3;
        key_mask = 4'b1111;
        for (n = 0; n < GUARD_TICKS && !last_status.press_event; n++) key_tick();
        for (n = 0; n < GUARD_TICKS && hold_cnt != 8'd255; n++) key_tick();
        key_tick();
        key_col = '0;
        for (n = 0; n < GUARD_TICKS && !last_status.release_event; n++) key_tick();
    endtask

    // Random key sessions with bounce, row changes and noise under small timings
    task automatic test_random_sessions(input int n_ticks, input int tx_pct, input int rx_pct);
        int start, span, kind, pause_at;
        load_timing(16'($urandom_range(3)), 16'($urandom_range(6)),
                    16'($urandom_range(25)), 16'($urandom_range(12)));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        noise_pct   = 3;
        start       = ticks_sent;
        pause_at    = start + $urandom_range(n_ticks / 4, 3 * n_ticks / 4);
        while (ticks_sent - start < n_ticks) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                // burst of raw row noise
                key_col = '0;
                repeat ($urandom_range(1, 12)) send_tick(NUM_ROWS'($urandom));
            end else begin
                key_col  = COL_BITS'($urandom_range(1, NUM_COLUMNS));
                key_mask = ($urandom_range(2) != 0) ? NUM_ROWS'(1 << $urandom_range(NUM_ROWS - 1))
                                                    : NUM_ROWS'($urandom_range(1, 15));
                // contact bounce
                repeat ($urandom_range(3)) send_tick(NUM_ROWS'($urandom));
                span = $urandom_range(1, 4 * (timing_regs[CFG_SETTLE] + 1)
                                       + timing_regs[CFG_DEBOUNCE] + timing_regs[CFG_LONG]
                                       + 3 * (timing_regs[CFG_REPEAT] + 1) + 10);
                for (int i = 0; i < span; i++) begin
                    if (kind >= 90 && i == span / 2) key_mask = NUM_ROWS'($urandom_range(1, 15));
                    key_tick();
                end
                key_col = '0;
                repeat ($urandom_range(1, 5 * (timing_regs[CFG_SETTLE] + 2) + 12)) key_tick();
            end
            if (ticks_sent >= pause_at) begin
                wait_idle();
                pause_at = start + n_ticks + 1;
            end
        end
        noise_pct = 0;
    endtask

    // Largest waits: the scan parks on its first wait while rows change at random
    task automatic test_max_waits();
        load_timing('1, '1, '1, '1);
        repeat (20) send_tick(NUM_ROWS'($urandom));
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        tick_ch.valid     <= 1'b0;
        tick_ch.row_lines <= '0;
        key_col     = '0;
        key_mask    = '0;
        noise_pct   = 0;
        tx_idle_pct = 21;
        rx_idle_pct = 47;
        ticks_sent  = 0;
        err_count   = 0;
        last_status = '0;
        reset_scanner();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timing();
        test_zero_waits();
        test_short_press();
        test_hold_wrap();
        test_random_sessions(210, 21, 47);
        test_random_sessions(210, 21, 47);
        test_random_sessions(210, 47, 21);
        test_random_sessions(210, 47, 21);
        test_random_sessions(210, 0, 0);
        test_random_sessions(210, 0, 0);
        test_max_waits();

        // Drain, then let any stray item show before the final check
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $display("%0t: %0d status items never arrived", $time, status_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("keypad_matrix_scan_debounce regression: pass");
        end else begin
            $display("keypad_matrix_scan_debounce regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("keypad_matrix_scan_debounce regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
